// ===== src/wktr_pkg.sv =====
// ============================================================================
// wktr_pkg: shared types and constants of the worst-k uncertainty tracker
// Holds the transfer payload structs, the ranked entry type, command codes
// and the rank ordering function used by every list cell.
// ============================================================================
package wktr_pkg;

  // List depth and stored index width
  localparam int MAX_KEEP   = 16;
  localparam int INDEX_BITS = 16;

  // Derived widths
  localparam int IDX_W  = (INDEX_BITS < 16) ? INDEX_BITS : 16;
  localparam int CNT_W  = $clog2(MAX_KEEP + 1);
  localparam int PTR_W  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int KEEP_W = 5;
  localparam int RANK_W = 4;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] point_index;
    logic [31:0] uncertainty_level;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [15:0]       worst_index;
    logic [31:0]       worst_level;
    logic              last_of_run;
    logic              list_empty;
  } out_item_t;

  // One held list entry
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [31:0]      level;
  } entry_t;

  // Pair a sorts strictly ahead of held entry b
  function automatic logic ranks_before(entry_t a, entry_t b);
    if (a.level != b.level) begin
      return a.level > b.level;
    end
    return a.idx > b.idx;
  endfunction

  // Clamp the written keep count to 1..MAX_KEEP
  function automatic logic [CNT_W-1:0] eff_keep(logic [KEEP_W-1:0] v);
    int k;
    k = int'(v);
    if (k < 1) begin
      k = 1;
    end
    if (k > MAX_KEEP) begin
      k = MAX_KEEP;
    end
    return CNT_W'(k);
  endfunction

endpackage

// ===== src/wktr_cell.sv =====
// ============================================================================
// wktr_cell: one slot of the sorted worst-k list
// Compares the incoming pair against its own entry and, on an insert, keeps
// its entry, takes the new pair, or takes its upstream neighbor's entry.
// ============================================================================
module wktr_cell (
  input  logic             clk,
  input  logic             ins_fire,
  input  logic             slot_valid,
  input  wktr_pkg::entry_t new_entry,
  input  wktr_pkg::entry_t prev_entry,
  input  logic             prev_ahead,
  output wktr_pkg::entry_t entry_q,
  output logic             ahead
);

  wktr_pkg::entry_t entry_r;
  wktr_pkg::entry_t entry_nxt;

  // An empty slot always counts the new pair as ahead
  assign ahead = !slot_valid || wktr_pkg::ranks_before(new_entry, entry_r);

  // Shift down from the neighbor, drop the new pair in, or hold
  always_comb begin
    entry_nxt = entry_r;
    if (ins_fire) begin
      if (prev_ahead) begin
        entry_nxt = prev_entry;
      end else if (ahead) begin
        entry_nxt = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

// ===== src/worst_k_uncertainty_tracker.sv =====
// ============================================================================
// worst_k_uncertainty_tracker: ranked list of the worst uncertainty points
// Row of compare-and-shift cells keeps pairs sorted by descending level,
// then descending index; readout streams the ranks through an output register.
// ============================================================================
// Insert and clear: one command accepted per cycle while idle with no keep-count write.
// Readout: one result per cycle unless out_ready stalls, count results (one for
//   an empty list); input is held off until the last result is loaded.
// First result is loaded once the sequencer enters its read state, then shows through the output register.
// Keep-count writes are taken only outside a readout and hold off input then.
// Synchronous active-low reset: list empty, keep count 16, output idle.
module worst_k_uncertainty_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wktr_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wktr_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wktr_pkg::KEEP_W-1:0]    cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                         state_r, state_nxt;
  logic [wktr_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [wktr_pkg::CNT_W-1:0]   keep_r, keep_nxt;
  logic [wktr_pkg::PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic                         out_valid_r, out_valid_nxt;
  wktr_pkg::out_item_t          out_data_r, out_data_nxt;

  wktr_pkg::entry_t             new_entry;
  wktr_pkg::entry_t             cell_q [wktr_pkg::MAX_KEEP];
  logic [wktr_pkg::MAX_KEEP-1:0] ahead;
  logic                         in_fire;
  logic                         ins_fire;
  logic                         fits;
  logic                         load;
  logic                         rd_last;
  logic [wktr_pkg::CNT_W-1:0]   new_keep;
  logic [wktr_pkg::CNT_W-1:0]   bumped;
  wktr_pkg::entry_t             rd_entry;

  // Config write wins the cycle; never during a readout
  assign in_ready  = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign ins_fire  = in_fire && (in_data.cmd == wktr_pkg::CMD_INSERT);

  assign new_entry.idx   = in_data.point_index[wktr_pkg::IDX_W-1:0];
  assign new_entry.level = in_data.uncertainty_level;

  // Cell row: cell 0 has no upstream neighbor
  for (genvar i = 0; i < wktr_pkg::MAX_KEEP; i++) begin : g_cell
    if (i == 0) begin : g_head
      wktr_cell u_cell (
        .clk        (clk),
        .ins_fire   (ins_fire),
        .slot_valid (count_r > wktr_pkg::CNT_W'(i)),
        .new_entry  (new_entry),
        .prev_entry (new_entry),
        .prev_ahead (1'b0),
        .entry_q    (cell_q[i]),
        .ahead      (ahead[i])
      );
    end else begin : g_body
      wktr_cell u_cell (
        .clk        (clk),
        .ins_fire   (ins_fire),
        .slot_valid (count_r > wktr_pkg::CNT_W'(i)),
        .new_entry  (new_entry),
        .prev_entry (cell_q[i-1]),
        .prev_ahead (ahead[i-1]),
        .entry_q    (cell_q[i]),
        .ahead      (ahead[i])
      );
    end
  end

  // The new pair lands inside the kept range
  assign fits     = ahead[wktr_pkg::PTR_W'(keep_r - 1'b1)];
  assign new_keep = wktr_pkg::eff_keep(cfg_data);
  assign bumped   = (count_r < keep_r) ? count_r + 1'b1 : keep_r;

  // Readout source and end-of-run detect
  assign rd_entry = cell_q[rd_ptr_r];
  assign rd_last  = (count_r == '0) ||
                    (wktr_pkg::CNT_W'(rd_ptr_r) + 1'b1 == count_r);
  assign load     = (state_r == ST_READ) && (!out_valid_r || out_ready);

  // Count, keep and sequencer
  always_comb begin
    count_nxt  = count_r;
    keep_nxt   = keep_r;
    state_nxt  = state_r;
    rd_ptr_nxt = rd_ptr_r;
    if (cfg_valid && cfg_ready) begin
      keep_nxt = new_keep;
      if (count_r > new_keep) begin
        count_nxt = new_keep;
      end
    end else if (in_fire) begin
      case (in_data.cmd)
        wktr_pkg::CMD_INSERT: begin
          if (fits) begin
            count_nxt = bumped;
          end
        end
        wktr_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        wktr_pkg::CMD_READ: begin
          state_nxt  = ST_READ;
          rd_ptr_nxt = '0;
        end
        default: begin
        end
      endcase
    end
    if (load) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
      if (rd_last) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (count_r == '0) begin
        out_data_nxt.rank        = '0;
        out_data_nxt.worst_index = '0;
        out_data_nxt.worst_level = '0;
        out_data_nxt.last_of_run = 1'b1;
        out_data_nxt.list_empty  = 1'b1;
      end else begin
        out_data_nxt.rank        = wktr_pkg::RANK_W'(rd_ptr_r);
        out_data_nxt.worst_index = 16'(rd_entry.idx);
        out_data_nxt.worst_level = rd_entry.level;
        out_data_nxt.last_of_run = rd_last;
        out_data_nxt.list_empty  = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      keep_r      <= wktr_pkg::eff_keep(wktr_pkg::KEEP_W'(16));
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      keep_r      <= keep_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/wktr_checker.sv =====
// ============================================================================
// wktr_checker: port-level checks for the worst-k uncertainty tracker
// Watches the transfer ports and flags readout sequencing slips.
// ============================================================================
module wktr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input wktr_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input wktr_pkg::out_item_t         out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Empty marker comes as a lone zero result
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.list_empty |->
      out_data.last_of_run && out_data.rank == '0 &&
      out_data.worst_index == '0 && out_data.worst_level == '0)
    else $error("malformed empty result");

  // A read command holds off input on the next cycle
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.cmd == wktr_pkg::CMD_READ |=> !in_ready)
    else $error("input taken during readout");

  // Readout in progress while a non-final result is shown
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_of_run |-> !in_ready)
    else $error("input ready before readout finished");

endmodule

bind worst_k_uncertainty_tracker wktr_checker u_wktr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
